@@ hw/rtl/tlvp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlvp_pkg
// Types and constants shared by the tag-length-value byte parser.
// ----------------------------------------------------------------------------
package tlvp_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned TAG_W    = 16;
	localparam int unsigned LEN_W    = 32;
	localparam int unsigned KIND_W   = 2;

	localparam logic [KIND_W-1:0] KIND_HEADER  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [KIND_W-1:0] KIND_STOP    = 2'd2;

	localparam logic [TAG_W-1:0] PIXEL_GROUP_STD  = 16'h7fe0;
	localparam logic [TAG_W-1:0] PIXEL_GROUP_ALT  = 16'h7fdf;
	localparam logic [TAG_W-1:0] PIXEL_ELEMENT    = 16'h0010;

	typedef enum logic [3:0] {
		PH_HDR0    = 4'd0,
		PH_HDR1    = 4'd1,
		PH_HDR2    = 4'd2,
		PH_HDR3    = 4'd3,
		PH_HDR4    = 4'd4,
		PH_HDR5    = 4'd5,
		PH_HDR6    = 4'd6,
		PH_HDR7    = 4'd7,
		PH_PAYLOAD = 4'd8,
		PH_STOPPED = 4'd9
	} phase_t;

	typedef struct packed {
		phase_t             phase;
		logic [TAG_W-1:0]   tag_group;
		logic [TAG_W-1:0]   tag_element;
		logic [LEN_W-1:0]   payload_length;
		logic [LEN_W-1:0]   payload_count;
	} parse_state_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [TAG_W-1:0]   group_number;
		logic [TAG_W-1:0]   element_number;
		logic [LEN_W-1:0]   value_length;
		logic [BYTE_W-1:0]  payload_byte;
		logic [LEN_W-1:0]   byte_index;
		logic               element_done;
	} result_t;

endpackage

@@ hw/rtl/tag_length_value_byte_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tag_length_value_byte_parser
// Byte-serial parser for little-endian tag, length and value elements.
// Path: input register, then result register. The parse state updates as the input
// register drains, one byte per cycle unless a stalled result holds it back.
// Reset: arst_n clears parse state, frame mode and both valid flags.
// ----------------------------------------------------------------------------
module tag_length_value_byte_parser (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic                            cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            action,
	input  logic [tlvp_pkg::BYTE_W-1:0]     data_byte,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [tlvp_pkg::KIND_W-1:0]     kind,
	output logic [tlvp_pkg::TAG_W-1:0]      group_number,
	output logic [tlvp_pkg::TAG_W-1:0]      element_number,
	output logic [tlvp_pkg::LEN_W-1:0]      value_length,
	output logic [tlvp_pkg::BYTE_W-1:0]     payload_byte,
	output logic [tlvp_pkg::LEN_W-1:0]      byte_index,
	output logic                            element_done
);

	logic                          frame_mode_q;
	logic                          valid_s1;
	logic                          action_s1;
	logic [tlvp_pkg::BYTE_W-1:0]   byte_s1;
	tlvp_pkg::parse_state_t        state_q;
	tlvp_pkg::parse_state_t        state_nxt;
	logic                          has_result;
	tlvp_pkg::result_t             result;
	logic                          out_valid_q;
	tlvp_pkg::result_t             out_q;
	logic                          out_free;
	logic                          advance;

	assign cfg_ready = 1'b1;

	// byte with no result drains regardless of the output side
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && (!has_result || out_free);
	assign in_stall = valid_s1 && !advance;

	tlvp_decode u_decode (
		.action     (action_s1),
		.data_byte  (byte_s1),
		.frame_mode (frame_mode_q),
		.cur        (state_q),
		.nxt        (state_nxt),
		.has_result (has_result),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			frame_mode_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			action_s1 <= action;
			byte_s1   <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: tlvp_pkg::PH_HDR0, default: '0};
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			out_q <= result;
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = out_q.kind;
	assign group_number   = out_q.group_number;
	assign element_number = out_q.element_number;
	assign value_length   = out_q.value_length;
	assign payload_byte   = out_q.payload_byte;
	assign byte_index     = out_q.byte_index;
	assign element_done   = out_q.element_done;

endmodule

@@ hw/rtl/tlvp_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlvp_decode
// Next-state and result logic for one stream byte or restart.
// ----------------------------------------------------------------------------
module tlvp_decode (
	input  logic                          action,
	input  logic [tlvp_pkg::BYTE_W-1:0]   data_byte,
	input  logic                          frame_mode,
	input  tlvp_pkg::parse_state_t        cur,
	output tlvp_pkg::parse_state_t        nxt,
	output logic                          has_result,
	output tlvp_pkg::result_t             result
);

	tlvp_pkg::phase_t             phase_eff;
	logic [tlvp_pkg::LEN_W-1:0]   len_full;
	logic [tlvp_pkg::LEN_W-1:0]   count_inc;
	logic                         is_pixel;

	always_comb begin
		// unused phase codes behave as header start
		phase_eff = (cur.phase > tlvp_pkg::PH_STOPPED) ? tlvp_pkg::PH_HDR0 : cur.phase;
		len_full  = {data_byte, cur.payload_length[23:0]};
		count_inc = cur.payload_count + 32'd1;
		is_pixel  = ((cur.tag_group == tlvp_pkg::PIXEL_GROUP_STD) ||
			(cur.tag_group == tlvp_pkg::PIXEL_GROUP_ALT)) &&
			(cur.tag_element == tlvp_pkg::PIXEL_ELEMENT);

		nxt        = cur;
		has_result = 1'b0;
		result.kind         = tlvp_pkg::KIND_HEADER;
		result.payload_byte = '0;
		result.byte_index   = '0;
		result.element_done = 1'b0;

		if (action) begin
			nxt.phase = tlvp_pkg::PH_HDR0;
		end else begin
			unique case (phase_eff)
				tlvp_pkg::PH_HDR0: begin
					nxt.tag_group = {8'd0, data_byte};
					nxt.phase     = tlvp_pkg::PH_HDR1;
				end
				tlvp_pkg::PH_HDR1: begin
					nxt.tag_group = {data_byte, cur.tag_group[7:0]};
					nxt.phase     = tlvp_pkg::PH_HDR2;
				end
				tlvp_pkg::PH_HDR2: begin
					nxt.tag_element = {8'd0, data_byte};
					nxt.phase       = tlvp_pkg::PH_HDR3;
				end
				tlvp_pkg::PH_HDR3: begin
					nxt.tag_element = {data_byte, cur.tag_element[7:0]};
					nxt.phase       = tlvp_pkg::PH_HDR4;
				end
				tlvp_pkg::PH_HDR4: begin
					nxt.payload_length = {24'd0, data_byte};
					nxt.phase          = tlvp_pkg::PH_HDR5;
				end
				tlvp_pkg::PH_HDR5: begin
					nxt.payload_length = {16'd0, data_byte, cur.payload_length[7:0]};
					nxt.phase          = tlvp_pkg::PH_HDR6;
				end
				tlvp_pkg::PH_HDR6: begin
					nxt.payload_length = {8'd0, data_byte, cur.payload_length[15:0]};
					nxt.phase          = tlvp_pkg::PH_HDR7;
				end
				tlvp_pkg::PH_HDR7: begin
					nxt.payload_length = len_full;
					nxt.payload_count  = '0;
					has_result         = 1'b1;
					if (frame_mode && is_pixel) begin
						nxt.phase   = tlvp_pkg::PH_STOPPED;
						result.kind = tlvp_pkg::KIND_STOP;
					end else if (len_full == '0) begin
						nxt.phase           = tlvp_pkg::PH_HDR0;
						result.element_done = 1'b1;
					end else begin
						nxt.phase = tlvp_pkg::PH_PAYLOAD;
					end
				end
				tlvp_pkg::PH_PAYLOAD: begin
					nxt.payload_count   = count_inc;
					has_result          = 1'b1;
					result.kind         = tlvp_pkg::KIND_PAYLOAD;
					result.payload_byte = data_byte;
					result.byte_index   = cur.payload_count;
					result.element_done = (count_inc == cur.payload_length);
					if (count_inc == cur.payload_length) begin
						nxt.phase = tlvp_pkg::PH_HDR0;
					end
				end
				tlvp_pkg::PH_STOPPED: begin
					nxt.phase = tlvp_pkg::PH_STOPPED;
				end
				default: begin
					nxt.phase = tlvp_pkg::PH_HDR0;
				end
			endcase
		end

		result.group_number   = nxt.tag_group;
		result.element_number = nxt.tag_element;
		result.value_length   = nxt.payload_length;
	end

endmodule

@@ bench/tag_length_value_byte_parser_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tag_length_value_byte_parser_test
// Self-checking bench for the tag, length and value byte parser. Element
// streams are driven in bursts with random gaps while the result side stalls
// on a cycle-based pattern. A shadow parser in the bench tracks the header
// phases, the payload count and the frame mode, and every result transaction
// is checked field by field against the oldest queued prediction.
// ----------------------------------------------------------------------------
module tag_length_value_byte_parser_test;

	logic                              clk        = 1'b0;
	logic                              arst_n     = 1'b0;
	logic                              cfg_valid  = 1'b0;
	logic                              cfg_ready;
	logic                              cfg_data   = 1'b0;
	logic                              in_valid   = 1'b0;
	logic                              in_stall;
	logic                              action     = 1'b0;
	logic [tlvp_pkg::BYTE_W-1:0]       data_byte  = '0;
	logic                              out_valid;
	logic                              out_stall  = 1'b0;
	logic [tlvp_pkg::KIND_W-1:0]       kind;
	logic [tlvp_pkg::TAG_W-1:0]        group_number;
	logic [tlvp_pkg::TAG_W-1:0]        element_number;
	logic [tlvp_pkg::LEN_W-1:0]        value_length;
	logic [tlvp_pkg::BYTE_W-1:0]       payload_byte;
	logic [tlvp_pkg::LEN_W-1:0]        byte_index;
	logic                              element_done;

	tlvp_pkg::parse_state_t            stream_state      = '0;
	logic                              frame_mode_shadow = 1'b0;
	tlvp_pkg::result_t                 element_events_due[$];
	int unsigned                       fail_count        = 0;
	int unsigned                       items_counted     = 0;
	int unsigned                       burst_left        = 0;
	logic [9:0]                        stall_tick        = '0;

	tag_length_value_byte_parser dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.action         (action),
		.data_byte      (data_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.kind           (kind),
		.group_number   (group_number),
		.element_number (element_number),
		.value_length   (value_length),
		.payload_byte   (payload_byte),
		.byte_index     (byte_index),
		.element_done   (element_done)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// shadow parser: advances on one accepted byte, returns 1 when a result is due
	function automatic logic parse_byte(input logic act,
			input logic [tlvp_pkg::BYTE_W-1:0] b, output tlvp_pkg::result_t r);
		logic emits;
		emits = 1'b0;
		r = '0;
		if (act) begin
			stream_state.phase = tlvp_pkg::PH_HDR0;
			return 1'b0;
		end
		if (stream_state.phase > tlvp_pkg::PH_STOPPED)
			stream_state.phase = tlvp_pkg::PH_HDR0;
		case (stream_state.phase)
			tlvp_pkg::PH_HDR0: begin
				stream_state.tag_group = {8'h00, b};
				stream_state.phase = tlvp_pkg::PH_HDR1;
			end
			tlvp_pkg::PH_HDR1: begin
				stream_state.tag_group[15:8] = b;
				stream_state.phase = tlvp_pkg::PH_HDR2;
			end
			tlvp_pkg::PH_HDR2: begin
				stream_state.tag_element = {8'h00, b};
				stream_state.phase = tlvp_pkg::PH_HDR3;
			end
			tlvp_pkg::PH_HDR3: begin
				stream_state.tag_element[15:8] = b;
				stream_state.phase = tlvp_pkg::PH_HDR4;
			end
			tlvp_pkg::PH_HDR4: begin
				stream_state.payload_length = {24'h000000, b};
				stream_state.phase = tlvp_pkg::PH_HDR5;
			end
			tlvp_pkg::PH_HDR5: begin
				stream_state.payload_length[15:8] = b;
				stream_state.phase = tlvp_pkg::PH_HDR6;
			end
			tlvp_pkg::PH_HDR6: begin
				stream_state.payload_length[23:16] = b;
				stream_state.phase = tlvp_pkg::PH_HDR7;
			end
			tlvp_pkg::PH_HDR7: begin
				stream_state.payload_length[31:24] = b;
				stream_state.payload_count = '0;
				emits = 1'b1;
				if (frame_mode_shadow &&
						stream_state.tag_element == tlvp_pkg::PIXEL_ELEMENT &&
						(stream_state.tag_group == tlvp_pkg::PIXEL_GROUP_STD ||
						stream_state.tag_group == tlvp_pkg::PIXEL_GROUP_ALT)) begin
					r.kind = tlvp_pkg::KIND_STOP;
					stream_state.phase = tlvp_pkg::PH_STOPPED;
				end else begin
					r.kind = tlvp_pkg::KIND_HEADER;
					r.element_done = (stream_state.payload_length == '0);
					if (r.element_done)
						stream_state.phase = tlvp_pkg::PH_HDR0;
					else
						stream_state.phase = tlvp_pkg::PH_PAYLOAD;
				end
			end
			tlvp_pkg::PH_PAYLOAD: begin
				r.kind = tlvp_pkg::KIND_PAYLOAD;
				r.payload_byte = b;
				r.byte_index = stream_state.payload_count;
				stream_state.payload_count = stream_state.payload_count + 32'd1;
				r.element_done = (stream_state.payload_count == stream_state.payload_length);
				if (r.element_done)
					stream_state.phase = tlvp_pkg::PH_HDR0;
				emits = 1'b1;
			end
			default: ;
		endcase
		r.group_number = stream_state.tag_group;
		r.element_number = stream_state.tag_element;
		r.value_length = stream_state.payload_length;
		return emits;
	endfunction

	// receiver stall pattern: quiet, sparse, periodic and heavy windows
	always @(posedge clk) begin
		stall_tick <= stall_tick + 1'b1;
		case (stall_tick[9:8])
			2'd0: out_stall <= 1'b0;
			2'd1: out_stall <= ($urandom_range(0, 3) == 0);
			2'd2: out_stall <= (stall_tick[4:0] > 5'd22);
			default: out_stall <= ($urandom_range(0, 1) == 0);
		endcase
	end

	always @(posedge clk) begin
		tlvp_pkg::result_t got;
		tlvp_pkg::result_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = {kind, group_number, element_number, value_length,
				payload_byte, byte_index, element_done};
			if (element_events_due.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result: kind %0d group %h element %h length %h",
						got.kind, got.group_number, got.element_number, got.value_length);
			end else begin
				want = element_events_due.pop_front();
				if (got.kind !== want.kind || got.group_number !== want.group_number ||
						got.element_number !== want.element_number ||
						got.value_length !== want.value_length ||
						got.payload_byte !== want.payload_byte ||
						got.byte_index !== want.byte_index ||
						got.element_done !== want.element_done) begin
					fail_count++;
					if (fail_count <= 10) begin
						$write("mismatch (expected/actual): kind %0d/%0d group %h/%h ",
							want.kind, got.kind, want.group_number, got.group_number);
						$display("element %h/%h length %h/%h byte %h/%h index %0d/%0d done %0b/%0b",
							want.element_number, got.element_number,
							want.value_length, got.value_length,
							want.payload_byte, got.payload_byte,
							want.byte_index, got.byte_index,
							want.element_done, got.element_done);
					end
				end
			end
		end
	end

	task automatic send_item(input logic act, input logic [tlvp_pkg::BYTE_W-1:0] b);
		tlvp_pkg::result_t ev;
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
			burst_left = $urandom_range(1, 20);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		action <= act;
		data_byte <= b;
		do @(posedge clk); while (in_stall);
		if (act || stream_state.phase != tlvp_pkg::PH_STOPPED)
			items_counted++;
		if (parse_byte(act, b, ev))
			element_events_due.push_back(ev);
	endtask

	task automatic restart_parse();
		send_item(1'b1, 8'($urandom));
	endtask

	task automatic send_header_range(input logic [63:0] hdr, input int lo, input int hi);
		for (int i = lo; i <= hi; i++)
			send_item(1'b0, hdr[8*i +: 8]);
	endtask

	task automatic send_element(input logic [tlvp_pkg::TAG_W-1:0] grp,
			input logic [tlvp_pkg::TAG_W-1:0] elm,
			input logic [tlvp_pkg::LEN_W-1:0] len, input int unsigned npay);
		send_header_range({len, elm, grp}, 0, 7);
		repeat (npay) send_item(1'b0, 8'($urandom));
	endtask

	// hold the sender until every predicted transaction is out and the pipe is empty
	task automatic settle_stream();
		in_valid <= 1'b0;
		burst_left = 0;
		while (element_events_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_mode(input logic mode);
		cfg_valid <= 1'b1;
		cfg_data <= mode;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		frame_mode_shadow = mode;
	endtask

	task automatic test_header_extremes();
		send_element(16'hffff, 16'hffff, 32'h0000_0000, 0);
		send_element(16'h0000, 16'h0000, 32'h0000_0001, 1);
	endtask

	task automatic test_restart_mid_header();
		send_header_range({32'h0000_0003, 16'h5678, 16'h1234}, 0, 2);
		restart_parse();
		send_element(16'h1234, 16'h5678, 32'h0000_0002, 2);
	endtask

	task automatic test_pixel_passthrough();
		send_element(tlvp_pkg::PIXEL_GROUP_ALT, tlvp_pkg::PIXEL_ELEMENT, 32'h0000_0001, 1);
	endtask

	task automatic test_frame_stop();
		settle_stream();
		write_mode(1'b1);
		send_element(tlvp_pkg::PIXEL_GROUP_STD, tlvp_pkg::PIXEL_ELEMENT, 32'hffff_ffff, 1);
		restart_parse();
		send_element(tlvp_pkg::PIXEL_GROUP_STD, 16'h0011, 32'h0000_0000, 0);
	endtask

	task automatic test_mode_sampling();
		send_header_range({32'h0000_0000, tlvp_pkg::PIXEL_ELEMENT,
			tlvp_pkg::PIXEL_GROUP_ALT}, 0, 3);
		settle_stream();
		write_mode(1'b0);
		send_header_range({32'h0000_0000, tlvp_pkg::PIXEL_ELEMENT,
			tlvp_pkg::PIXEL_GROUP_ALT}, 4, 7);
	endtask

	task automatic test_random_stream(input logic mode, input int unsigned n);
		int unsigned goal;
		int unsigned pick;
		int unsigned npay;
		logic [tlvp_pkg::TAG_W-1:0] grp;
		logic [tlvp_pkg::TAG_W-1:0] elm;
		logic [tlvp_pkg::LEN_W-1:0] len;
		settle_stream();
		write_mode(mode);
		goal = items_counted + n;
		while (items_counted < goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				repeat ($urandom_range(1, 7)) send_item(1'b0, 8'($urandom));
				restart_parse();
			end else if (pick < 16) begin
				repeat ($urandom_range(1, 4))
					send_item($urandom_range(0, 3) == 0, 8'($urandom));
			end else begin
				if (stream_state.phase != tlvp_pkg::PH_HDR0)
					restart_parse();
				pick = $urandom_range(0, 99);
				grp = (pick < 15) ? tlvp_pkg::PIXEL_GROUP_STD :
					(pick < 27) ? tlvp_pkg::PIXEL_GROUP_ALT : 16'($urandom);
				elm = ($urandom_range(0, 2) == 0) ? tlvp_pkg::PIXEL_ELEMENT : 16'($urandom);
				pick = $urandom_range(0, 99);
				if (pick < 70)
					len = $urandom_range(0, 6);
				else if (pick < 85)
					len = $urandom_range(7, 20);
				else
					len = $urandom;
				npay = (len > 20) ? $urandom_range(0, 5) : len;
				if (len <= 20 && $urandom_range(0, 9) == 0)
					npay = $urandom_range(0, len);
				send_element(grp, elm, len, npay);
				if (stream_state.phase == tlvp_pkg::PH_STOPPED)
					repeat ($urandom_range(0, 3)) send_item(1'b0, 8'($urandom));
				if (stream_state.phase != tlvp_pkg::PH_HDR0)
					restart_parse();
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_mode(1'b0);
		test_header_extremes();
		test_restart_mid_header();
		test_pixel_passthrough();
		test_frame_stop();
		test_mode_sampling();
		test_random_stream(1'b0, 320);
		test_random_stream(1'b1, 320);
		test_random_stream(1'b0, 300);
		test_random_stream(1'b1, 310);
		in_valid <= 1'b0;
		for (int k = 0; k < 5000 && element_events_due.size() != 0; k++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		fail_count += element_events_due.size();
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/tlvp_pkg.sv
hw/rtl/tlvp_decode.sv
hw/rtl/tag_length_value_byte_parser.sv
bench/tag_length_value_byte_parser_test.sv
